### rtl/melody_note_sequencer_defines.svh
// Assertion macros shared by the melody note sequencer RTL.
// Depends on nothing; included by the top level only.
`ifndef MELODY_NOTE_SEQUENCER_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MNS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define MNS_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/mns_pkg.sv
// Package of the melody note sequencer: action and register codes, beat and state types.
// Depends on nothing; used by the interfaces and every module of the block.
package mns_pkg;

   localparam int MAX_TUNE     = 256;
   localparam int TUNE_LEN_W   = 9;
   localparam int START_SLOT_W = 8;
   localparam int CSR_DATA_W   = 9;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_START = 2'd2,
      ACT_STOP  = 2'd3
   } action_type;

   typedef enum logic {
      CSR_TUNE_START_SLOT = 1'b0,
      CSR_TUNE_LENGTH     = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] now_ms;
      logic [7:0]  slot;
      logic [15:0] note_freq;
      logic [15:0] note_duration;
   } req_beat_type;

   typedef struct packed {
      logic [15:0] duration;
      logic [15:0] freq;
   } note_entry_type;

   typedef struct packed {
      logic [15:0]           drive_freq;
      logic                  drive_on;
      logic                  melody_active;
      logic [TUNE_LEN_W-1:0] play_index;
   } play_state_type;

endpackage

### rtl/mns_req_if.sv
// Request channel of the melody note sequencer: valid/ready plus one input beat.
// Depends on mns_pkg.
interface mns_req_if;
   import mns_pkg::*;

   logic        valid;
   logic        ready;
   action_type  action;
   logic [31:0] now_ms;
   logic [7:0]  slot;
   logic [15:0] note_freq;
   logic [15:0] note_duration;

   modport source (output valid, action, now_ms, slot, note_freq, note_duration,
                   input ready);
   modport sink   (input valid, action, now_ms, slot, note_freq, note_duration,
                   output ready);
endinterface

### rtl/mns_rsp_if.sv
// Response channel of the melody note sequencer: valid/ready plus one result beat.
// Depends on mns_pkg.
interface mns_rsp_if;
   import mns_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [15:0]           tone_freq;
   logic                  tone_on;
   logic                  playing;
   logic [TUNE_LEN_W-1:0] note_index;

   modport source (output valid, tone_freq, tone_on, playing, note_index, input ready);
   modport sink   (input valid, tone_freq, tone_on, playing, note_index, output ready);
endinterface

### rtl/mns_note_store.sv
// Note store: one write port and one registered read port with write-to-read bypass.
// Depends on mns_pkg.
module mns_note_store #(
   parameter int NOTE_SLOTS = 256,
   parameter int AW         = 8
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  mns_pkg::note_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output mns_pkg::note_entry_type rd_data
);
   import mns_pkg::*;

   note_entry_type note_mem_ff [NOTE_SLOTS];
   note_entry_type rd_data_ff;

   // A load to the slot being fetched in the same cycle returns the new note.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= note_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/mns_play_core.sv
// Playback state and per-beat update of the melody note sequencer.
// Depends on mns_pkg; fed by mns_note_store with the note at the current tune position.
module mns_play_core #(
   parameter int NOTE_SLOTS = 256,
   parameter int AW         = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  mns_pkg::req_beat_type                 beat,
   input  logic [mns_pkg::TUNE_LEN_W-1:0]        tune_length,
   input  logic [AW-1:0]                         start_mod,
   input  mns_pkg::note_entry_type               entry,
   output logic [AW-1:0]                         rd_addr,
   output mns_pkg::play_state_type               state
);
   import mns_pkg::*;

   play_state_type        state_ff;
   play_state_type        state_in;
   logic [31:0]           next_due_ff;
   logic [31:0]           next_due_in;
   logic [AW-1:0]         pidx_mod_ff;
   logic [AW-1:0]         pidx_mod_in;
   logic [TUNE_LEN_W-1:0] len_eff;
   logic [31:0]           diff_now;
   logic [31:0]           due_sum;
   logic [31:0]           diff_late;
   logic [AW:0]           addr_sum;

   always_comb begin
      state_in    = state_ff;
      next_due_in = next_due_ff;
      pidx_mod_in = pidx_mod_ff;
      len_eff     = (tune_length > TUNE_LEN_W'(MAX_TUNE)) ? TUNE_LEN_W'(MAX_TUNE) : tune_length;
      diff_now    = beat.now_ms - next_due_ff;
      due_sum     = next_due_ff + {16'd0, entry.duration};
      diff_late   = beat.now_ms - due_sum;

      if (advance) begin
         case (beat.action)
            ACT_TICK: begin
               if (state_ff.melody_active && !diff_now[31]) begin
                  if (state_ff.play_index >= len_eff) begin
                     state_in.melody_active = 1'b0;
                     state_in.drive_on      = 1'b0;
                  end else begin
                     if (entry.freq == 16'd0) begin
                        state_in.drive_on = 1'b0;
                     end else begin
                        state_in.drive_freq = entry.freq;
                        state_in.drive_on   = 1'b1;
                     end
                     // Running late: re-base instead of replaying missed notes.
                     if (!diff_late[31]) begin
                        next_due_in = beat.now_ms + {16'd0, entry.duration};
                     end else begin
                        next_due_in = due_sum;
                     end
                     state_in.play_index = state_ff.play_index + TUNE_LEN_W'(1);
                     if (pidx_mod_ff == AW'(NOTE_SLOTS - 1)) begin
                        pidx_mod_in = '0;
                     end else begin
                        pidx_mod_in = pidx_mod_ff + AW'(1);
                     end
                  end
               end
            end
            ACT_START: begin
               state_in.play_index    = '0;
               state_in.melody_active = 1'b1;
               pidx_mod_in            = '0;
               next_due_in            = beat.now_ms - 32'd1;
            end
            ACT_STOP: begin
               state_in.melody_active = 1'b0;
               state_in.drive_freq    = '0;
               state_in.drive_on      = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // Fetch the note for the position the next beat will see.
      addr_sum = {1'b0, start_mod} + {1'b0, pidx_mod_in};
      if (addr_sum >= (AW+1)'(NOTE_SLOTS)) begin
         rd_addr = AW'(addr_sum - (AW+1)'(NOTE_SLOTS));
      end else begin
         rd_addr = AW'(addr_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= '0;
         next_due_ff <= '0;
         pidx_mod_ff <= '0;
      end else begin
         state_ff    <= state_in;
         next_due_ff <= next_due_in;
         pidx_mod_ff <= pidx_mod_in;
      end
   end

   assign state = state_ff;
endmodule

### rtl/melody_note_sequencer.sv
// Melody note sequencer top level: input beat register, playback core, note store.
// An accepted beat is held in the input register, then processed into the playback state and rsp valid registers.
// Throughput: one beat per cycle unless rsp stalls; the core's due compare, add and fetch address are combinational.
// Reset is synchronous and active high: playback idle, tone off, both tune registers zero.
// The note store has no reset; a slot holds garbage until a load beat writes it.
`include "melody_note_sequencer_defines.svh"

module melody_note_sequencer #(
   parameter int NOTE_SLOTS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   mns_req_if.sink                           req,
   mns_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  mns_pkg::csr_index_type            csr_index,
   input  logic [mns_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mns_pkg::*;

   localparam int AW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;

   // Every 8-bit slot number reduced modulo the store depth, built at elaboration.
   function automatic logic [256*AW-1:0] build_slot_mod();
      logic [256*AW-1:0] tbl;
      tbl = '0;
      for (int i = 0; i < 256; i++) begin
         tbl[i*AW +: AW] = AW'(i % NOTE_SLOTS);
      end
      return tbl;
   endfunction

   localparam logic [256*AW-1:0] SLOT_MOD = build_slot_mod();

   logic                    in_valid_ff;
   logic                    in_valid_in;
   req_beat_type            in_beat_ff;
   req_beat_type            in_beat_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [START_SLOT_W-1:0] start_slot_ff;
   logic [START_SLOT_W-1:0] start_slot_in;
   logic [TUNE_LEN_W-1:0]   tune_len_ff;
   logic [TUNE_LEN_W-1:0]   tune_len_in;
   logic                    advance;
   logic [AW-1:0]           start_mod;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   note_entry_type          wr_data;
   note_entry_type          rd_entry;
   play_state_type          play_state;

   // The beat in the input register is processed when the result register is
   // free or is being emptied this cycle. The input register can take a new
   // beat whenever it is empty or its beat moves on, so one beat waits in the
   // input register while a finished result waits for the consumer.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_beat_in = in_beat_ff;
      if (req.valid && req.ready) begin
         in_valid_in              = 1'b1;
         in_beat_in.action        = req.action;
         in_beat_in.now_ms        = req.now_ms;
         in_beat_in.slot          = req.slot;
         in_beat_in.note_freq     = req.note_freq;
         in_beat_in.note_duration = req.note_duration;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end

      // Register writes land at the edge; the fetch address below already uses
      // the new start slot so the next tick reads the right note.
      start_slot_in = start_slot_ff;
      tune_len_in   = tune_len_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TUNE_START_SLOT: start_slot_in = csr_wdata[START_SLOT_W-1:0];
            CSR_TUNE_LENGTH:     tune_len_in   = csr_wdata[TUNE_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         start_slot_ff <= '0;
         tune_len_ff   <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         start_slot_ff <= start_slot_in;
         tune_len_ff   <= tune_len_in;
      end
      in_beat_ff <= in_beat_in;
   end

   assign start_mod = SLOT_MOD[start_slot_in*AW +: AW];

   // A load beat writes its note into the store as it is processed.
   assign wr_en            = advance && (in_beat_ff.action == ACT_LOAD);
   assign wr_addr          = SLOT_MOD[in_beat_ff.slot*AW +: AW];
   assign wr_data.freq     = in_beat_ff.note_freq;
   assign wr_data.duration = in_beat_ff.note_duration;

   mns_note_store #(
      .NOTE_SLOTS (NOTE_SLOTS),
      .AW         (AW)
   ) u_note_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   mns_play_core #(
      .NOTE_SLOTS (NOTE_SLOTS),
      .AW         (AW)
   ) u_play_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .beat        (in_beat_ff),
      .tune_length (tune_len_ff),
      .start_mod   (start_mod),
      .entry       (rd_entry),
      .rd_addr     (rd_addr),
      .state       (play_state)
   );

   // The playback state only changes when a result is loaded, so the result
   // beat is the state itself; it holds while the consumer stalls.
   assign rsp.valid      = out_valid_ff;
   assign rsp.tone_freq  = play_state.drive_freq;
   assign rsp.tone_on    = play_state.drive_on;
   assign rsp.playing    = play_state.melody_active;
   assign rsp.note_index = play_state.play_index;

   // The tone is only switched on together with a nonzero frequency.
   `MNS_ASSERT_ALWAYS(a_tone_on_has_freq, clock, reset, (!play_state.drive_on || play_state.drive_freq != 16'd0), "tone on with zero frequency")
   // The tune position never passes the longest tune.
   `MNS_ASSERT_ALWAYS(a_index_bound, clock, reset, (play_state.play_index <= TUNE_LEN_W'(MAX_TUNE)), "note index beyond longest tune")
   // A processed stop silences the output and ends play.
   `MNS_ASSERT_NEXT(a_stop_silences, clock, reset, (advance && in_beat_ff.action == ACT_STOP), (!play_state.melody_active && !play_state.drive_on && play_state.drive_freq == 16'd0), "stop did not silence")
   // A processed start arms play from the first note.
   `MNS_ASSERT_NEXT(a_start_arms, clock, reset, (advance && in_beat_ff.action == ACT_START), (play_state.melody_active && play_state.play_index == '0), "start did not arm play")

endmodule

### bench/mns_playback_check.sv
// Playback checker for the melody note sequencer: watches both channels and the tune registers.
// Depends on mns_pkg and the mns_req_if / mns_rsp_if interfaces of the RTL.
module mns_playback_check #(
   parameter int NOTE_SLOTS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   mns_req_if                             req,
   mns_rsp_if                             rsp,
   input  logic                           csr_we,
   input  mns_pkg::csr_index_type         csr_index,
   input  logic [mns_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             waiting_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mns_pkg::*;

   // Shadow copy of the player: tune registers, note store and playback state.
   logic [START_SLOT_W-1:0] tune_base;
   logic [TUNE_LEN_W-1:0]   tune_len;
   note_entry_type          note_store [NOTE_SLOTS];
   logic [TUNE_LEN_W-1:0]   cursor;
   logic [31:0]             due_ms;
   logic                    active;
   logic [15:0]             freq_out;
   logic                    tone_out;

   play_state_type          predicted_tone [$];

   // Wrap-safe compare: the due time has come when now minus due is not negative.
   function automatic bit time_reached(logic [31:0] now, logic [31:0] due);
      logic [31:0] diff;
      diff = now - due;
      return !diff[31];
   endfunction

   // Applies one beat to the shadow state and returns the tone outputs after it.
   function automatic play_state_type play_beat(req_beat_type b);
      int             span;
      note_entry_type note;
      play_state_type outs;
      case (b.action)
         ACT_TICK: begin
            if (active && time_reached(b.now_ms, due_ms)) begin
               span = (int'(tune_len) > MAX_TUNE) ? MAX_TUNE : int'(tune_len);
               if (int'(cursor) >= span) begin
                  active   = 1'b0;
                  tone_out = 1'b0;
               end else begin
                  note = note_store[(int'(tune_base) + int'(cursor)) % NOTE_SLOTS];
                  if (note.freq == 16'd0) begin
                     tone_out = 1'b0;
                  end else begin
                     freq_out = note.freq;
                     tone_out = 1'b1;
                  end
                  due_ms = due_ms + 32'(note.duration);
                  // Already late: re-base instead of bursting catch-up notes.
                  if (time_reached(b.now_ms, due_ms))
                     due_ms = b.now_ms + 32'(note.duration);
                  cursor = cursor + 1'b1;
               end
            end
         end
         ACT_LOAD: begin
            note_store[int'(b.slot) % NOTE_SLOTS] = '{duration: b.note_duration,
                                                      freq: b.note_freq};
         end
         ACT_START: begin
            cursor = '0;
            active = 1'b1;
            due_ms = b.now_ms - 32'd1;
         end
         ACT_STOP: begin
            active   = 1'b0;
            freq_out = 16'd0;
            tone_out = 1'b0;
         end
         default: ;
      endcase
      outs.drive_freq    = freq_out;
      outs.drive_on      = tone_out;
      outs.melody_active = active;
      outs.play_index    = cursor;
      return outs;
   endfunction

   always @(posedge clock) begin
      req_beat_type   beat;
      play_state_type want;
      if (reset) begin
         tune_base      = '0;
         tune_len       = '0;
         cursor         = '0;
         due_ms         = '0;
         active         = 1'b0;
         freq_out       = '0;
         tone_out       = 1'b0;
         mismatch_count = 0;
         predicted_tone.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TUNE_START_SLOT: tune_base = csr_wdata[START_SLOT_W-1:0];
               CSR_TUNE_LENGTH:     tune_len  = csr_wdata[TUNE_LEN_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            beat.action        = req.action;
            beat.now_ms        = req.now_ms;
            beat.slot          = req.slot;
            beat.note_freq     = req.note_freq;
            beat.note_duration = req.note_duration;
            predicted_tone.push_back(play_beat(beat));
         end
         if (rsp.valid && rsp.ready) begin
            if (predicted_tone.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected result freq=%0d on=%0b play=%0b idx=%0d",
                           $realtime, rsp.tone_freq, rsp.tone_on, rsp.playing, rsp.note_index);
               mismatch_count++;
            end else begin
               want = predicted_tone.pop_front();
               if (rsp.tone_freq !== want.drive_freq || rsp.tone_on !== want.drive_on ||
                   rsp.playing !== want.melody_active || rsp.note_index !== want.play_index) begin
                  if (mismatch_count < 10)
                     $display("%0t: want f=%0d on=%0b p=%0b i=%0d, got f=%0d on=%0b p=%0b i=%0d",
                              $realtime, want.drive_freq, want.drive_on, want.melody_active,
                              want.play_index, rsp.tone_freq, rsp.tone_on, rsp.playing,
                              rsp.note_index);
                  mismatch_count++;
               end
            end
         end
      end
      waiting_count = predicted_tone.size();
   end

endmodule

### bench/tb_melody_note_sequencer.sv
// Top of the melody note sequencer bench: clock, reset, beat stimulus, tune registers, verdict.
// Depends on mns_pkg, the RTL interfaces, melody_note_sequencer and mns_playback_check.
module tb_melody_note_sequencer;
   timeunit 1ns;
   timeprecision 1ps;
   import mns_pkg::*;

   localparam int NOTE_SLOTS = 256;
   // The longest stretch of a correct run without a request beat is a send gap
   // while the result side stalls, or the drain and settle before a register
   // write. This limit is many times that.
   localparam int STALL_LIMIT = 2000;
   // Stop making random beats once about this many have been accepted.
   localparam int BEAT_TARGET = 850;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int waiting_count;
   int beats_sent;
   int quiet_cycles;
   bit quiet_stretch;

   mns_req_if req_ch();
   mns_rsp_if rsp_ch();

   melody_note_sequencer #(.NOTE_SLOTS(NOTE_SLOTS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mns_playback_check #(.NOTE_SLOTS(NOTE_SLOTS)) playback_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .waiting_count  (waiting_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Each side waits a random gap before each beat, except during a quiet stretch
   // where both sides run flat out.
   function automatic int draw_gap();
      return quiet_stretch ? 0 : $urandom_range(0, 12);
   endfunction

   // Note content for loads: pauses and the top frequency show up often, and
   // durations are mostly short so that tunes move along under small time steps.
   function automatic logic [15:0] draw_freq();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         return 16'd0;
      else if (pick < 25)
         return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] draw_duration();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return 16'($urandom_range(0, 12));
      else if (pick < 90)
         return 16'($urandom_range(13, 300));
      else if (pick < 97)
         return 16'($urandom);
      return 16'hFFFF;
   endfunction

   // Drives one request beat, starting and ending at a falling edge. Valid is
   // only lowered when a gap is drawn, so back-to-back beats keep it high.
   task automatic send_beat(action_type act, logic [31:0] now, logic [7:0] slot,
                            logic [15:0] freq, logic [15:0] dur);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.action        <= act;
      req_ch.now_ms        <= now;
      req_ch.slot          <= slot;
      req_ch.note_freq     <= freq;
      req_ch.note_duration <= dur;
      req_ch.valid         <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // Ticks, starts and stops carry random junk in the fields they do not use.
   task automatic send_ctrl(action_type act, logic [31:0] now);
      send_beat(act, now, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic send_load(logic [7:0] slot, logic [15:0] freq, logic [15:0] dur);
      send_beat(ACT_LOAD, $urandom, slot, freq, dur);
   endtask

   // The tune registers are only written with the block idle: the request side
   // is parked, every predicted beat has come back, and the pipeline
   // has had time to empty.
   task automatic write_tune(logic [7:0] base, logic [8:0] len);
      req_ch.valid <= 1'b0;
      while (waiting_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TUNE_START_SLOT;
      csr_wdata <= CSR_DATA_W'(base);
      @(negedge clock);
      csr_index <= CSR_TUNE_LENGTH;
      csr_wdata <= len;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Result side: ready follows its own random stall pattern.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Watchdog: the run is hung if no request beat is taken for too long.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] t;
      logic [7:0]  base;
      logic [8:0]  len;
      int          phase;
      int          steps;
      int          pick;

      // Every input of the block starts from a known value.
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_TUNE_START_SLOT;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.action        = ACT_TICK;
      req_ch.now_ms        = '0;
      req_ch.slot          = '0;
      req_ch.note_freq     = '0;
      req_ch.note_duration = '0;
      beats_sent           = 0;
      quiet_stretch        = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. With an empty tune, a start followed by a tick ends
      // play at once without touching the store; ticks and stops while idle
      // change nothing.
      write_tune(8'd0, 9'd0);
      send_ctrl(ACT_TICK, 32'd0);
      send_ctrl(ACT_STOP, 32'd0);
      send_ctrl(ACT_START, 32'd0);
      send_ctrl(ACT_TICK, 32'd0);

      // A four-note tune that wraps from the top slot back to slot 0: the top
      // frequency, a pause, a note of the longest duration and a note of zero
      // duration.
      send_load(8'd255, 16'hFFFF, 16'd3);
      send_load(8'd0, 16'd0, 16'd2);
      send_load(8'd1, 16'd1, 16'hFFFF);
      send_load(8'd2, 16'h8000, 16'd0);
      write_tune(8'd255, 9'd4);

      // Start just below the 32-bit wrap so the due compare must be wrap safe.
      send_ctrl(ACT_START, 32'hFFFF_FFFE);
      send_ctrl(ACT_TICK, 32'hFFFF_FFFE);
      send_ctrl(ACT_TICK, 32'hFFFF_FFFF);
      // Arriving late: the pause plays and the due time is re-based on now.
      send_ctrl(ACT_TICK, 32'h0000_0010);
      send_ctrl(ACT_TICK, 32'h0000_0012);
      // A load lands in the store while the tune is playing.
      send_load(8'd3, 16'h1234, 16'd5);
      // The zero-duration note, then the tick that ends the tune.
      send_ctrl(ACT_TICK, 32'h0001_0011);
      send_ctrl(ACT_TICK, 32'h0001_0011);
      // Restart while playing, stop while playing, then a tick while stopped.
      send_ctrl(ACT_START, 32'h8000_0000);
      send_ctrl(ACT_TICK, 32'h8000_0000);
      send_ctrl(ACT_START, 32'h8000_0001);
      send_ctrl(ACT_STOP, 32'h8000_0001);
      send_ctrl(ACT_TICK, 32'h8000_0002);

      // Fill the whole store so that any tune register setting, the oversized
      // length included, only ever reads loaded notes.
      for (int s = 0; s < NOTE_SLOTS; s++)
         send_load(8'(s), draw_freq(), draw_duration());

      // Random phases: mostly well-formed play with a start followed by ticks
      // of rising time, mixed with loads, stops, restarts, jumps and stray
      // times. Each phase picks its own tune registers.
      phase = 0;
      while (beats_sent < BEAT_TARGET) begin
         case (phase)
            0: begin base = 8'd0; len = 9'd256; end
            1: begin base = 8'd255; len = 9'h1FF; end
            2: begin base = 8'($urandom); len = 9'd0; end
            default: begin
               base = 8'($urandom);
               pick = $urandom_range(0, 9);
               if (pick == 0)
                  len = 9'($urandom);
               else if (pick == 1)
                  len = 9'd256;
               else
                  len = 9'($urandom_range(1, 12));
            end
         endcase
         write_tune(base, len);
         quiet_stretch = ($urandom_range(0, 3) == 0);

         pick = $urandom_range(0, 3);
         if (pick == 0)
            t = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
         else if (pick == 1)
            t = 32'h7FFF_FFF0 + 32'($urandom_range(0, 15));
         else
            t = $urandom;
         send_ctrl(ACT_START, t);

         steps = $urandom_range(10, 40);
         for (int i = 0; i < steps; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               t = t + 32'($urandom_range(0, 6));
               send_ctrl(ACT_TICK, t);
            end else if (pick < 66) begin
               t = t + 32'($urandom_range(1000, 70000));
               send_ctrl(ACT_TICK, t);
            end else if (pick < 68) begin
               // A jump of half the clock range or more looks like time going back.
               t = t + $urandom;
               send_ctrl(ACT_TICK, t);
            end else if (pick < 73) begin
               send_ctrl(ACT_TICK, $urandom);
            end else if (pick < 83) begin
               send_load(8'($urandom), draw_freq(), draw_duration());
            end else if (pick < 88) begin
               send_ctrl(ACT_STOP, t);
            end else if (pick < 93) begin
               send_ctrl(ACT_START, t);
            end else begin
               send_ctrl(ACT_TICK, t);
            end
         end
         phase++;
      end

      // Drain: park the request side, let every predicted beat come back,
      // then keep watching so that a stray late beat can show itself.
      req_ch.valid <= 1'b0;
      while (waiting_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && waiting_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
